### sv/tllq_pkg.sv
// ============================================================================
// Three-level linked queue scheduler package
// Shared widths, command and status codes, sequencer states and the structs
// that pass between the sequencer and the top level.
// ============================================================================
package tllq_pkg;

    localparam int CMD_W = 3;
    localparam int ENT_W = 6;
    localparam int LVL_W = 2;
    localparam int STS_W = 2;
    localparam int CNT_W = 7;

    // Default table size.
    localparam int DEF_ENTRIES = 64;

    // Three real levels plus the "no level" code, so that every level code
    // indexes the level registers.
    localparam int LVL_SLOTS = 4;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PICK = 3'd4;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY     = 2'd1;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [STS_W-1:0] STS_QUEUED    = 2'd3;

    localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_TOP  = 2'd2;
    localparam logic [LVL_W-1:0] LVL_NONE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EVAL,
        ST_UL_P,
        ST_UL_N,
        ST_UL_E,
        ST_LINK,
        ST_LINK_T,
        ST_LINK_E,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ENT_W-1:0] entry;
        logic             entry_valid;
        logic [LVL_W-1:0] src_queue;
        logic [LVL_W-1:0] dst_queue;
    } t_cmd;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [ENT_W-1:0] result_entry;
        logic             result_valid;
        logic [CNT_W-1:0] level_count;
    } t_result;

endpackage

### sv/three_level_linked_queue_scheduler.sv
// ============================================================================
// Three-level linked queue scheduler
// Three doubly linked FIFO levels over a table of entries, with enqueue,
// dequeue, remove, move and pick-next commands; one result word per command.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ---------------------------------
//  command   in         i_valid / o_ready    i_cmd, i_entry, i_entry_valid,
//                                            i_src_queue, i_dst_queue
//  result    out        o_valid / i_ready    o_status, o_result_entry,
//                                            o_result_valid, o_level_count
//
//  After reset the link table is cleared entry by entry, during which
//  o_ready stays low. Checks that fail on the level registers, and pick
//  next with no current entry, end at decode; a move from the middle of
//  a list takes the longest path: read, unlink prev, next and entry, then
//  link at the tail. The steps follow the link memory, which gives one
//  read and one write per cycle. A finished result waits in the output
//  register; the next command is taken meanwhile and stalls only at its
//  own end if the result is not taken.
//
module three_level_linked_queue_scheduler #(
    parameter int ENTRIES = tllq_pkg::DEF_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tllq_pkg::CMD_W-1:0]  i_cmd,
    input  logic [tllq_pkg::ENT_W-1:0]  i_entry,
    input  logic                        i_entry_valid,
    input  logic [tllq_pkg::LVL_W-1:0]  i_src_queue,
    input  logic [tllq_pkg::LVL_W-1:0]  i_dst_queue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tllq_pkg::STS_W-1:0]  o_status,
    output logic [tllq_pkg::ENT_W-1:0]  o_result_entry,
    output logic                        o_result_valid,
    output logic [tllq_pkg::CNT_W-1:0]  o_level_count
);
    import tllq_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int WW = 2 + 2 * LW;

    t_cmd          cmd;
    t_result       seq_res;
    logic          seq_idle;
    logic          seq_res_valid;
    logic          seq_res_ready;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [WW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    // Output register: holds a finished result until the consumer takes it.
    logic          r_out_valid;
    t_result       r_out;

    assign cmd.cmd         = i_cmd;
    assign cmd.entry       = i_entry;
    assign cmd.entry_valid = i_entry_valid;
    assign cmd.src_queue   = i_src_queue;
    assign cmd.dst_queue   = i_dst_queue;

    assign o_ready       = seq_idle;
    assign seq_res_ready = !r_out_valid || i_ready;

    tllq_seq #(
        .ENTRIES(ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_valid),
        .i_cmd       (cmd),
        .o_idle      (seq_idle),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_res       (seq_res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // Each word holds an entry's level tag, prev link and next link.
    tllq_link_ram #(
        .DEPTH(ENTRIES),
        .WIDTH(WW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_res_valid && seq_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid && seq_res_ready) begin
            r_out <= seq_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_entry = r_out.result_entry;
    assign o_result_valid = r_out.result_valid;
    assign o_level_count  = r_out.level_count;

`ifndef SYNTHESIS
    // A result names an entry exactly when the command succeeded.
    a_status_vs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == STS_OK) == o_result_valid))
        else $error("status and result_valid disagree");

    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_valid) |-> (o_result_entry == '0))
        else $error("result_entry not zero without an entry");

    // An accepted command occupies the sequencer for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("command taken while sequencer busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level_count <= 7'd64))
        else $error("level count beyond table reach");
`endif

endmodule

### sv/tllq_link_ram.sv
// ============================================================================
// Link table memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ============================================================================
module tllq_link_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/tllq_seq.sv
// ============================================================================
// Queue command sequencer
// Holds the level head, tail and size registers and walks each command
// through read-modify-write steps on the link table memory.
// ============================================================================
module tllq_seq #(
    parameter int ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  tllq_pkg::t_cmd             i_cmd,
    output logic                       o_idle,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output tllq_pkg::t_result          o_res,
    output logic                       o_rd_en,
    output logic [$clog2(ENTRIES)-1:0] o_rd_addr,
    input  logic [1+2*$clog2(ENTRIES+1):0] i_rd_data,
    output logic                       o_wr_en,
    output logic [$clog2(ENTRIES)-1:0] o_wr_addr,
    output logic [1+2*$clog2(ENTRIES+1):0] o_wr_data
);
    import tllq_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int WW = 2 + 2 * LW;
    localparam logic [LW-1:0] LINK_NULL = LW'(ENTRIES);
    localparam logic [AW-1:0] LAST_IDX  = AW'(ENTRIES - 1);

    // Memory word: level tag, prev link, next link.
    function automatic logic [WW-1:0] pack_word(input logic [LVL_W-1:0] tag,
                                                input logic [LW-1:0] prv,
                                                input logic [LW-1:0] nxt);
        return {tag, prv, nxt};
    endfunction

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [AW-1:0]     r_head [LVL_SLOTS];
    logic [AW-1:0]     n_head [LVL_SLOTS];
    logic [AW-1:0]     r_tail [LVL_SLOTS];
    logic [AW-1:0]     n_tail [LVL_SLOTS];
    logic [CNT_W-1:0]  r_size [LVL_SLOTS];
    logic [CNT_W-1:0]  n_size [LVL_SLOTS];
    logic [AW-1:0]     r_clr_idx, n_clr_idx;
    logic [AW-1:0]     r_tgt, n_tgt;
    logic [LW-1:0]     r_p, n_p;
    logic [LW-1:0]     r_n, n_n;
    logic [STS_W-1:0]  r_status, n_status;
    logic [ENT_W-1:0]  r_res_entry, n_res_entry;
    logic              r_res_valid, n_res_valid;
    logic [LVL_W-1:0]  r_res_lvl, n_res_lvl;

    logic [LVL_W-1:0]  rd_tag;
    logic [LW-1:0]     rd_prev;
    logic [LW-1:0]     rd_next;
    logic              e_ok;
    logic [LVL_W-1:0]  src;
    logic [LVL_W-1:0]  dst;
    logic [CNT_W-1:0]  dec_size;

    assign rd_tag  = i_rd_data[WW-1 -: LVL_W];
    assign rd_prev = i_rd_data[2*LW-1 -: LW];
    assign rd_next = i_rd_data[LW-1:0];
    assign e_ok    = 32'(r_cmd.entry) < ENTRIES;
    assign src     = r_cmd.src_queue;
    assign dst     = r_cmd.dst_queue;
    assign dec_size = r_size[src] - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            for (int i = 0; i < LVL_SLOTS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_size[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_size    <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_tgt       <= n_tgt;
        r_p         <= n_p;
        r_n         <= n_n;
        r_status    <= n_status;
        r_res_entry <= n_res_entry;
        r_res_valid <= n_res_valid;
        r_res_lvl   <= n_res_lvl;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_head      = r_head;
        n_tail      = r_tail;
        n_size      = r_size;
        n_clr_idx   = r_clr_idx;
        n_tgt       = r_tgt;
        n_p         = r_p;
        n_n         = r_n;
        n_status    = r_status;
        n_res_entry = r_res_entry;
        n_res_valid = r_res_valid;
        n_res_lvl   = r_res_lvl;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_tgt;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_tgt;
        o_wr_data   = pack_word(LVL_NONE, LINK_NULL, LINK_NULL);

        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr_idx;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_state = ST_DECODE;
                end
            end

            // Checks that need only the level registers; otherwise fetch the
            // word of the entry the command works on.
            ST_DECODE: begin
                n_status    = STS_EMPTY;
                n_res_valid = 1'b0;
                n_res_entry = '0;
                n_res_lvl   = LVL_NONE;
                n_state     = ST_DONE;
                n_tgt       = AW'(r_cmd.entry);
                unique case (r_cmd.cmd)
                    CMD_ENQ: begin
                        if (dst != LVL_NONE) begin
                            n_res_lvl = dst;
                            if (!e_ok) begin
                                n_status = STS_NOT_FOUND;
                            end else begin
                                n_state = ST_EVAL;
                            end
                        end
                    end
                    CMD_DEQ: begin
                        if (src != LVL_NONE && r_size[src] != '0) begin
                            n_tgt   = r_head[src];
                            n_state = ST_EVAL;
                        end
                    end
                    CMD_REM: begin
                        if (src != LVL_NONE && r_size[src] != '0) begin
                            n_res_lvl = src;
                            if (!e_ok) begin
                                n_status = STS_NOT_FOUND;
                            end else begin
                                n_state = ST_EVAL;
                            end
                        end
                    end
                    CMD_MOVE: begin
                        if (src != LVL_NONE && dst != LVL_NONE) begin
                            n_res_lvl = dst;
                            if (r_size[src] == '0) begin
                                n_status = STS_EMPTY;
                            end else if (!e_ok) begin
                                n_status = STS_NOT_FOUND;
                            end else begin
                                n_state = ST_EVAL;
                            end
                        end
                    end
                    CMD_PICK: begin
                        n_res_lvl = LVL_TOP;
                        if (!r_cmd.entry_valid) begin
                            if (r_size[LVL_TOP] != '0) begin
                                n_status    = STS_OK;
                                n_res_valid = 1'b1;
                                n_res_entry = ENT_W'(r_head[LVL_TOP]);
                            end
                        end else if (!e_ok) begin
                            n_status = STS_NOT_FOUND;
                        end else begin
                            n_state = ST_EVAL;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
                o_rd_en   = (n_state == ST_EVAL);
                o_rd_addr = n_tgt;
            end

            // The target word is on the read port.
            ST_EVAL: begin
                n_p = rd_prev;
                n_n = rd_next;
                n_state = ST_DONE;
                priority if (r_cmd.cmd == CMD_ENQ) begin
                    if (rd_tag != LVL_NONE) begin
                        n_status = STS_QUEUED;
                    end else begin
                        n_state = ST_LINK;
                    end
                end else if (r_cmd.cmd == CMD_PICK) begin
                    n_status    = STS_OK;
                    n_res_valid = 1'b1;
                    if (rd_next == LINK_NULL) begin
                        if (r_size[LVL_TOP] != '0) begin
                            n_res_entry = ENT_W'(r_head[LVL_TOP]);
                        end else if (r_size[LVL_MID] != '0) begin
                            n_res_entry = ENT_W'(r_head[LVL_MID]);
                        end else begin
                            n_status    = STS_EMPTY;
                            n_res_valid = 1'b0;
                        end
                    end else if (r_size[LVL_TOP] != '0 && rd_tag == LVL_MID) begin
                        n_res_entry = ENT_W'(r_head[LVL_TOP]);
                    end else begin
                        n_res_entry = ENT_W'(rd_next);
                    end
                end else if (r_cmd.cmd != CMD_DEQ && rd_tag != src) begin
                    n_status = STS_NOT_FOUND;
                end else begin
                    // Start unlinking: fix the neighbors first.
                    if (rd_prev != LINK_NULL) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(rd_prev);
                        n_state   = ST_UL_P;
                    end else if (rd_next != LINK_NULL) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(rd_next);
                        n_state   = ST_UL_N;
                    end else begin
                        n_state = ST_UL_E;
                    end
                end
            end

            ST_UL_P: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_p);
                o_wr_data = pack_word(rd_tag, rd_prev, r_n);
                if (r_n != LINK_NULL) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(r_n);
                    n_state   = ST_UL_N;
                end else begin
                    n_state = ST_UL_E;
                end
            end

            ST_UL_N: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_n);
                o_wr_data = pack_word(rd_tag, r_p, rd_next);
                n_state   = ST_UL_E;
            end

            ST_UL_E: begin
                o_wr_en = 1'b1;
                if (r_p == LINK_NULL && r_n != LINK_NULL) begin
                    n_head[src] = AW'(r_n);
                end
                if (r_n == LINK_NULL && r_p != LINK_NULL) begin
                    n_tail[src] = AW'(r_p);
                end
                n_size[src] = dec_size;
                if (dec_size == '0) begin
                    n_head[src] = '0;
                    n_tail[src] = '0;
                end
                if (r_cmd.cmd == CMD_MOVE) begin
                    n_state = ST_LINK;
                end else begin
                    n_status    = STS_OK;
                    n_res_valid = 1'b1;
                    n_res_entry = ENT_W'(r_tgt);
                    n_res_lvl   = src;
                    n_state     = ST_DONE;
                end
            end

            ST_LINK: begin
                if (r_size[dst] == '0) begin
                    o_wr_en     = 1'b1;
                    o_wr_data   = pack_word(dst, LINK_NULL, LINK_NULL);
                    n_head[dst] = r_tgt;
                    n_tail[dst] = r_tgt;
                    n_size[dst] = CNT_W'(1);
                    n_status    = STS_OK;
                    n_res_valid = 1'b1;
                    n_res_entry = ENT_W'(r_tgt);
                    n_res_lvl   = dst;
                    n_state     = ST_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_tail[dst];
                    n_state   = ST_LINK_T;
                end
            end

            ST_LINK_T: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_tail[dst];
                o_wr_data = pack_word(rd_tag, rd_prev, LW'(r_tgt));
                n_state   = ST_LINK_E;
            end

            ST_LINK_E: begin
                o_wr_en     = 1'b1;
                o_wr_data   = pack_word(dst, LW'(r_tail[dst]), LINK_NULL);
                n_tail[dst] = r_tgt;
                n_size[dst] = r_size[dst] + CNT_W'(1);
                n_status    = STS_OK;
                n_res_valid = 1'b1;
                n_res_entry = ENT_W'(r_tgt);
                n_res_lvl   = dst;
                n_state     = ST_DONE;
            end

            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The level code LVL_NONE selects a size register that always holds zero.
    assign o_res.status       = r_status;
    assign o_res.result_entry = r_res_valid ? r_res_entry : '0;
    assign o_res.result_valid = r_res_valid;
    assign o_res.level_count  = r_size[r_res_lvl];

endmodule

### dv/three_level_linked_queue_scheduler_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Three-level linked queue scheduler testbench
// Drives command words through the valid/ready channel, tracks the three
// linked levels in a scoreboard that predicts every result word, and checks
// each returned word field by field under sender and receiver idling.
// ============================================================================
module three_level_linked_queue_scheduler_tb;

    import tllq_pkg::*;

    localparam int ENTRY_COUNT     = DEF_ENTRIES;
    localparam int LINK_W          = ENT_W + 1;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int REPORT_LIMIT    = 10;
    localparam int TIMEOUT_NS      = 1_000_000;

    localparam logic [LINK_W-1:0] LINK_NULL      = LINK_W'(ENTRY_COUNT);
    localparam logic [LVL_W-1:0]  LVL_LOW        = 2'd0;
    localparam logic [CMD_W-1:0]  CMD_UNUSED_LO  = CMD_PICK + 3'd1;
    localparam logic [CMD_W-1:0]  CMD_UNUSED_HI  = '1;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the linked levels and the words they produce.
    // ------------------------------------------------------------------------
    class linked_queue_tracker;
        logic [LINK_W-1:0] next_of  [ENTRY_COUNT];
        logic [LINK_W-1:0] prev_of  [ENTRY_COUNT];
        logic [LVL_W-1:0]  level_of [ENTRY_COUNT];
        logic [ENT_W-1:0]  head_of  [3];
        logic [ENT_W-1:0]  tail_of  [3];
        logic [CNT_W-1:0]  count_of [3];
        t_result           scheduler_answers [$];
        int                failures;

        function new();
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                next_of[i]  = LINK_NULL;
                prev_of[i]  = LINK_NULL;
                level_of[i] = LVL_NONE;
            end
            for (int q = 0; q < 3; q++) begin
                head_of[q]  = '0;
                tail_of[q]  = '0;
                count_of[q] = '0;
            end
            failures = 0;
        endfunction

        function t_result make_word(logic [STS_W-1:0] sts, logic [ENT_W-1:0] ent,
                                    logic rv, logic [CNT_W-1:0] cnt);
            t_result w;
            w.status       = sts;
            w.result_entry = rv ? ent : '0;
            w.result_valid = rv;
            w.level_count  = cnt;
            return w;
        endfunction

        function void link_at_tail(logic [ENT_W-1:0] e, logic [LVL_W-1:0] q);
            level_of[e] = q;
            next_of[e]  = LINK_NULL;
            if (count_of[q] == 0) begin
                prev_of[e] = LINK_NULL;
                head_of[q] = e;
            end else begin
                prev_of[e]          = {1'b0, tail_of[q]};
                next_of[tail_of[q]] = {1'b0, e};
            end
            tail_of[q]  = e;
            count_of[q] = count_of[q] + 1'b1;
        endfunction

        function void unlink(logic [ENT_W-1:0] e, logic [LVL_W-1:0] q);
            logic [LINK_W-1:0] p;
            logic [LINK_W-1:0] n;
            p = prev_of[e];
            n = next_of[e];
            if (p != LINK_NULL) begin
                next_of[p[ENT_W-1:0]] = n;
            end else if (n != LINK_NULL) begin
                head_of[q] = n[ENT_W-1:0];
            end
            if (n != LINK_NULL) begin
                prev_of[n[ENT_W-1:0]] = p;
            end else if (p != LINK_NULL) begin
                tail_of[q] = p[ENT_W-1:0];
            end
            if (count_of[q] != 0) begin
                count_of[q] = count_of[q] - 1'b1;
            end
            if (count_of[q] == 0) begin
                head_of[q] = '0;
                tail_of[q] = '0;
            end
            level_of[e] = LVL_NONE;
            next_of[e]  = LINK_NULL;
            prev_of[e]  = LINK_NULL;
        endfunction

        // Updates the shadow levels for one command and returns its result word.
        function t_result apply_queue_command(t_cmd c);
            logic [ENT_W-1:0] e;
            logic [LVL_W-1:0] s;
            logic [LVL_W-1:0] d;
            logic [CNT_W-1:0] top_count;
            logic [ENT_W-1:0] choice;
            e         = c.entry;
            s         = c.src_queue;
            d         = c.dst_queue;
            top_count = count_of[LVL_TOP];
            case (c.cmd)
                CMD_ENQ: begin
                    if (d == LVL_NONE) return make_word(STS_EMPTY, '0, 1'b0, '0);
                    if (level_of[e] != LVL_NONE)
                        return make_word(STS_QUEUED, '0, 1'b0, count_of[d]);
                    link_at_tail(e, d);
                    return make_word(STS_OK, e, 1'b1, count_of[d]);
                end
                CMD_DEQ: begin
                    if (s == LVL_NONE || count_of[s] == 0)
                        return make_word(STS_EMPTY, '0, 1'b0, '0);
                    choice = head_of[s];
                    unlink(choice, s);
                    return make_word(STS_OK, choice, 1'b1, count_of[s]);
                end
                CMD_REM: begin
                    if (s == LVL_NONE || count_of[s] == 0)
                        return make_word(STS_EMPTY, '0, 1'b0, '0);
                    if (level_of[e] != s)
                        return make_word(STS_NOT_FOUND, '0, 1'b0, count_of[s]);
                    unlink(e, s);
                    return make_word(STS_OK, e, 1'b1, count_of[s]);
                end
                CMD_MOVE: begin
                    if (s == LVL_NONE || d == LVL_NONE)
                        return make_word(STS_EMPTY, '0, 1'b0, '0);
                    if (count_of[s] == 0)
                        return make_word(STS_EMPTY, '0, 1'b0, count_of[d]);
                    if (level_of[e] != s)
                        return make_word(STS_NOT_FOUND, '0, 1'b0, count_of[d]);
                    unlink(e, s);
                    link_at_tail(e, d);
                    return make_word(STS_OK, e, 1'b1, count_of[d]);
                end
                CMD_PICK: begin
                    if (!c.entry_valid) begin
                        if (top_count == 0) return make_word(STS_EMPTY, '0, 1'b0, top_count);
                        return make_word(STS_OK, head_of[LVL_TOP], 1'b1, top_count);
                    end
                    // End of a list (or no list at all) wraps to the top level,
                    // then the middle one; level 0 is never a wrap target.
                    if (next_of[e] == LINK_NULL) begin
                        if (top_count != 0) begin
                            choice = head_of[LVL_TOP];
                        end else if (count_of[LVL_MID] != 0) begin
                            choice = head_of[LVL_MID];
                        end else begin
                            return make_word(STS_EMPTY, '0, 1'b0, top_count);
                        end
                    end else if (top_count != 0 && level_of[e] == LVL_MID) begin
                        choice = head_of[LVL_TOP];
                    end else begin
                        choice = next_of[e][ENT_W-1:0];
                    end
                    return make_word(STS_OK, choice, 1'b1, top_count);
                end
                default: begin
                    return make_word(STS_EMPTY, '0, 1'b0, '0);
                end
            endcase
        endfunction

        function void note_command(t_cmd c);
            scheduler_answers.push_back(apply_queue_command(c));
        endfunction

        function void report_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
        endfunction

        function void check_answer(t_result got);
            t_result want;
            if (scheduler_answers.size() == 0) begin
                report_failure($sformatf("unexpected word: sts=%0d ent=%0d rv=%0d cnt=%0d",
                    got.status, got.result_entry, got.result_valid, got.level_count));
                return;
            end
            want = scheduler_answers.pop_front();
            if (got.status !== want.status || got.result_entry !== want.result_entry ||
                got.result_valid !== want.result_valid ||
                got.level_count !== want.level_count) begin
                report_failure({
                    $sformatf("mismatch: expected sts=%0d ent=%0d rv=%0d cnt=%0d,",
                        want.status, want.result_entry, want.result_valid,
                        want.level_count),
                    $sformatf(" got sts=%0d ent=%0d rv=%0d cnt=%0d",
                        got.status, got.result_entry, got.result_valid,
                        got.level_count)});
            end
        endfunction

        function int pending();
            return scheduler_answers.size();
        endfunction

        function int queued_total();
            return int'(count_of[0]) + int'(count_of[1]) + int'(count_of[2]);
        endfunction

        // Chooses a random entry that currently sits in some level.
        function bit pick_queued(output logic [ENT_W-1:0] e, output logic [LVL_W-1:0] lvl);
            int k;
            e   = '0;
            lvl = LVL_NONE;
            if (queued_total() == 0) return 1'b0;
            k = $urandom_range(0, queued_total() - 1);
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (level_of[i] != LVL_NONE) begin
                    if (k == 0) begin
                        e   = ENT_W'(i);
                        lvl = level_of[i];
                        return 1'b1;
                    end
                    k--;
                end
            end
            return 1'b0;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, ports and the block.
    // ------------------------------------------------------------------------
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic             o_ready;
    logic [CMD_W-1:0] i_cmd         = '0;
    logic [ENT_W-1:0] i_entry       = '0;
    logic             i_entry_valid = 1'b0;
    logic [LVL_W-1:0] i_src_queue   = '0;
    logic [LVL_W-1:0] i_dst_queue   = '0;
    logic             o_valid;
    logic             i_ready       = 1'b0;
    logic [STS_W-1:0] o_status;
    logic [ENT_W-1:0] o_result_entry;
    logic             o_result_valid;
    logic [CNT_W-1:0] o_level_count;

    linked_queue_tracker sb;
    int tx_idle_pct = 7;
    int rx_idle_pct = 73;
    bit hold_req    = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    three_level_linked_queue_scheduler u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_entry        (i_entry),
        .i_entry_valid  (i_entry_valid),
        .i_src_queue    (i_src_queue),
        .i_dst_queue    (i_dst_queue),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_result_entry (o_result_entry),
        .o_result_valid (o_result_valid),
        .o_level_count  (o_level_count)
    );

    // ------------------------------------------------------------------------
    // Command side. Called at a falling edge; returns at the falling edge
    // after the word was taken, so the payload never lingers past acceptance.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_cmd w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_cmd         = w.cmd;
        i_entry       = w.entry;
        i_entry_valid = w.entry_valid;
        i_src_queue   = w.src_queue;
        i_dst_queue   = w.dst_queue;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_command(w);
        @(negedge i_clk);
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, logic [ENT_W-1:0] e, logic ev,
                         logic [LVL_W-1:0] src, logic [LVL_W-1:0] dst);
        t_cmd w;
        w.cmd         = cmd;
        w.entry       = e;
        w.entry_valid = ev;
        w.src_queue   = src;
        w.dst_queue   = dst;
        send_word(w);
    endtask

    // Directed walk over the corner cases; comments give the level contents.
    task automatic run_directed();
        issue(CMD_PICK, 6'd0,  1'b0, LVL_LOW,  LVL_LOW);   // nothing queued at all
        issue(CMD_DEQ,  6'd0,  1'b0, LVL_LOW,  LVL_LOW);   // empty level
        issue(CMD_ENQ,  6'd0,  1'b0, LVL_LOW,  LVL_LOW);   // L0: 0
        issue(CMD_ENQ,  6'd63, 1'b0, LVL_LOW,  LVL_LOW);   // L0: 0 63
        issue(CMD_ENQ,  6'd0,  1'b0, LVL_LOW,  LVL_MID);   // already queued
        issue(CMD_ENQ,  6'd7,  1'b0, LVL_LOW,  LVL_NONE);  // no such level
        issue(CMD_ENQ,  6'd5,  1'b0, LVL_LOW,  LVL_TOP);   // L2: 5
        issue(CMD_ENQ,  6'd10, 1'b0, LVL_LOW,  LVL_MID);
        issue(CMD_ENQ,  6'd11, 1'b0, LVL_LOW,  LVL_MID);   // L1: 10 11
        issue(CMD_PICK, 6'd10, 1'b1, LVL_LOW,  LVL_LOW);   // middle level yields to top
        issue(CMD_PICK, 6'd0,  1'b1, LVL_LOW,  LVL_LOW);   // plain next link
        issue(CMD_PICK, 6'd63, 1'b1, LVL_LOW,  LVL_LOW);   // end of list wraps to top
        issue(CMD_PICK, 6'd20, 1'b1, LVL_LOW,  LVL_LOW);   // current entry in no level
        issue(CMD_MOVE, 6'd0,  1'b0, LVL_LOW,  LVL_LOW);   // same level: L0: 63 0
        issue(CMD_MOVE, 6'd0,  1'b0, LVL_LOW,  LVL_TOP);   // L0: 63, L2: 5 0
        issue(CMD_MOVE, 6'd63, 1'b0, LVL_NONE, LVL_MID);   // no such source level
        issue(CMD_MOVE, 6'd5,  1'b0, LVL_MID,  LVL_LOW);   // not in the source level
        issue(CMD_REM,  6'd10, 1'b0, LVL_NONE, LVL_LOW);   // no such level
        issue(CMD_REM,  6'd11, 1'b0, LVL_MID,  LVL_LOW);   // tail out: L1: 10
        issue(CMD_REM,  6'd5,  1'b0, LVL_TOP,  LVL_LOW);   // head out: L2: 0
        issue(CMD_REM,  6'd5,  1'b0, LVL_LOW,  LVL_LOW);   // not in the source level
        issue(CMD_DEQ,  6'd0,  1'b0, LVL_NONE, LVL_LOW);   // no such level
        issue(CMD_DEQ,  6'd0,  1'b0, LVL_TOP,  LVL_LOW);   // last one: L2 empty
        issue(CMD_PICK, 6'd10, 1'b1, LVL_LOW,  LVL_LOW);   // wrap falls back to middle
        issue(CMD_MOVE, 6'd63, 1'b0, LVL_TOP,  LVL_MID);   // empty source level
        issue(CMD_DEQ,  6'd0,  1'b0, LVL_MID,  LVL_LOW);   // only L0: 63 remains
        issue(CMD_PICK, 6'd63, 1'b1, LVL_LOW,  LVL_LOW);   // wrap never lands on level 0
        issue(CMD_UNUSED_LO, 6'd63, 1'b1, LVL_TOP, LVL_TOP);
        issue(CMD_UNUSED_HI, 6'd0,  1'b0, LVL_LOW, LVL_LOW);
    endtask

    // Mostly well-formed traffic: removes, moves and picks usually name an
    // entry that is really queued, so the lists stay populated and the
    // middle-of-list relinking gets exercised. The rest is random noise.
    function automatic t_cmd random_word();
        t_cmd             w;
        int               roll;
        int               enq_share;
        bit               found;
        logic [ENT_W-1:0] qe;
        logic [LVL_W-1:0] ql;
        w.cmd         = CMD_ENQ;
        w.entry       = ENT_W'($urandom);
        w.entry_valid = 1'($urandom);
        w.src_queue   = LVL_W'($urandom);
        w.dst_queue   = LVL_W'($urandom);
        enq_share     = (sb.queued_total() < 32) ? 40 : 18;
        roll          = $urandom_range(0, 99);
        found         = sb.pick_queued(qe, ql);
        if (roll < enq_share) begin
            if ($urandom_range(0, 9) != 0) w.dst_queue = LVL_W'($urandom_range(0, 2));
        end else if (roll < enq_share + 12) begin
            w.cmd = CMD_DEQ;
            if ($urandom_range(0, 9) != 0) w.src_queue = LVL_W'($urandom_range(0, 2));
        end else if (roll < enq_share + 47) begin
            w.cmd = (roll < enq_share + 27) ? CMD_REM : CMD_MOVE;
            if (found && $urandom_range(0, 4) != 0) begin
                w.entry     = qe;
                w.src_queue = ql;
            end
            if ($urandom_range(0, 9) != 0) w.dst_queue = LVL_W'($urandom_range(0, 2));
        end else if (roll < 96) begin
            w.cmd = CMD_PICK;
            if (found && $urandom_range(0, 9) < 7) w.entry = qe;
            if ($urandom_range(0, 4) != 0) w.entry_valid = 1'b1;
        end else begin
            w.cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready pattern with a single long hold-off.
    // ------------------------------------------------------------------------
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready  = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            sb.check_answer('{status: o_status, result_entry: o_result_entry,
                              result_valid: o_result_valid, level_count: o_level_count});
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The block clears its link table first; send_word simply waits for
        // ready to rise.
        run_directed();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 73;
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 7;
                end
                default: begin
                    // No idling, but the receiver first stops for a long
                    // stretch so the result register backs up into the input.
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_req    = 1'b1;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_word(random_word());
        end
        i_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/tllq_pkg.sv
sv/tllq_link_ram.sv
sv/tllq_seq.sv
sv/three_level_linked_queue_scheduler.sv
dv/three_level_linked_queue_scheduler_tb.sv
